>>> src/bnb_pkg.sv
// ----------------------------------------------------------------------------
// bnb_pkg
// Shared types, codes and saturation helpers of the batch normalization
// backward block.
// ----------------------------------------------------------------------------
package bnb_pkg;

  typedef logic signed [47:0] acc_t;
  typedef logic signed [31:0] q_t;

  localparam acc_t ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam acc_t ACC_MIN = 48'sh8000_0000_0000;
  localparam q_t   Q_MAX   = 32'sh7FFF_FFFF;
  localparam q_t   Q_MIN   = 32'sh8000_0000;
  localparam int unsigned DIV_STEPS = 31;

  typedef enum logic [1:0] {
    REG_SCALE   = 2'd0,
    REG_MEAN    = 2'd1,
    REG_INV_STD = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_DXHAT,
    OP_XHAT,
    OP_R2,
    OP_T1,
    OP_CT,
    OP_DG,
    OP_MT,
    OP_CX,
    OP_DX
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DXHAT,
    ST_XHAT,
    ST_R2,
    ST_T1,
    ST_CT,
    ST_DG,
    ST_ACC,
    ST_DIV,
    ST_MT,
    ST_CX,
    ST_INNER,
    ST_DX,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_e mul_op;
    logic    acc;
    logic    inner;
    logic    div_start;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic out_busy;
    logic grad_pass;
    logic last;
  } sts_t;

  function automatic acc_t sat48(input logic signed [49:0] v);
    acc_t r;
    if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
      r = v[47:0];
    end else if (v[49]) begin
      r = ACC_MIN;
    end else begin
      r = ACC_MAX;
    end
    return r;
  endfunction

  function automatic q_t sat32(input acc_t v);
    q_t r;
    if (v[47:31] == 17'h00000 || v[47:31] == 17'h1FFFF) begin
      r = v[31:0];
    end else if (v[47]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

endpackage

>>> src/batchnorm_backward_channel.sv
// ----------------------------------------------------------------------------
// batchnorm_backward_channel
// Batch normalization backward pass for one channel, Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Software writes scale, mean and inverse std through the cfg channel while
// the block is idle; cfg_ready_o is always high. Elements arrive on the in
// channel, first an accumulate pass, then a gradient pass. One item is worked
// on at a time; all products go through one shared multiplier, which forms
// each product from three 48x16 partial products between an issue and a finish step.
// Accumulate item: no result.
// Last accumulate item: adds a 31-step serial divide and gives one channel
// result (scale and shift gradients).
// Gradient item: one element result per item; after the last one the
// channel sums, count and factor clear.
// Results sit in an output register; a new item is accepted while a result
// waits, and the next result waits until the receiver takes the pending one.
// Reset loads scale and inverse std with 1.0, mean with 0, and clears sums.
// ----------------------------------------------------------------------------
module batchnorm_backward_channel #(
  parameter int unsigned MAX_ELEMENTS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [31:0] grad_out_i,
  input  logic signed [31:0] activation_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] input_gradient_o,
  output logic signed [31:0] scale_gradient_o,
  output logic signed [31:0] shift_gradient_o,
  output logic               kind_o,
  output logic               last_result_o
);

  bnb_pkg::cmd_t cmd;
  bnb_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  bnb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bnb_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action_i),
    .grad_out_i       (grad_out_i),
    .activation_i     (activation_i),
    .last_element_i   (last_element_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .input_gradient_o (input_gradient_o),
    .scale_gradient_o (scale_gradient_o),
    .shift_gradient_o (shift_gradient_o),
    .kind_o           (kind_o),
    .last_result_o    (last_result_o)
  );

endmodule

>>> src/bnb_mul.sv
// ----------------------------------------------------------------------------
// bnb_mul
// Shared Q16.16 multiplier: sign-magnitude, three 48x16 partial products,
// then a truncating shift and 48-bit saturation.
// ----------------------------------------------------------------------------
module bnb_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bnb_pkg::acc_t     a_i,
  input  bnb_pkg::acc_t     b_i,
  output logic              done_o,
  output bnb_pkg::acc_t     res_o
);

  logic          busy_q;
  logic [1:0]    phase_q;
  logic          done_q;
  logic [47:0]   am_q;
  logic [47:0]   bm_q;
  logic          neg_q;
  logic [95:0]   prod_q;
  bnb_pkg::acc_t res_q;

  logic [47:0]   a_mag;
  logic [47:0]   b_mag;
  logic [63:0]   pp;
  logic [95:0]   prod_next;
  logic [79:0]   mag;
  bnb_pkg::acc_t res_next;

  assign a_mag     = a_i[47] ? 48'(-a_i) : 48'(a_i);
  assign b_mag     = b_i[47] ? 48'(-b_i) : 48'(b_i);
  assign pp        = 64'(am_q) * 64'(bm_q[47:32]);
  assign prod_next = {prod_q[79:0], 16'h0000} + {32'h0, pp};
  assign mag       = prod_q[95:16];

  always_comb begin
    if (|mag[79:47]) begin
      res_next = neg_q ? bnb_pkg::ACC_MIN : bnb_pkg::ACC_MAX;
    end else if (neg_q) begin
      res_next = -$signed(mag[47:0]);
    end else begin
      res_next = $signed(mag[47:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q  <= 1'b1;
        phase_q <= 2'd0;
      end else if (busy_q) begin
        if (phase_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          phase_q <= phase_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      am_q   <= a_mag;
      bm_q   <= b_mag;
      neg_q  <= a_i[47] ^ b_i[47];
      prod_q <= '0;
    end else if (busy_q) begin
      if (phase_q == 2'd3) begin
        res_q <= res_next;
      end else begin
        prod_q <= prod_next;
        bm_q   <= {bm_q[31:0], 16'h0000};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/bnb_div.sv
// ----------------------------------------------------------------------------
// bnb_div
// Restoring divider, one quotient bit per cycle: inverse std over count.
// ----------------------------------------------------------------------------
module bnb_div #(
  parameter int unsigned CNT_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [30:0]      num_i,
  input  logic [CNT_W-1:0] den_i,
  output logic             done_o,
  output logic [30:0]      quo_o
);

  logic             busy_q;
  logic [4:0]       cnt_q;
  logic             done_q;
  logic [30:0]      quo_q;
  logic [CNT_W:0]   rem_q;

  logic [CNT_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[CNT_W-1:0], quo_q[30]};
  assign ge     = rem_sh >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(bnb_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[29:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, den_i}) : rem_sh;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> src/bnb_dp.sv
// ----------------------------------------------------------------------------
// bnb_dp
// Datapath: configuration registers, item registers, channel accumulators,
// shared multiplier and divider, output register.
// ----------------------------------------------------------------------------
module bnb_dp #(
  parameter int unsigned MAX_ELEMENTS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bnb_pkg::cmd_t      cmd_i,
  output bnb_pkg::sts_t      sts_o,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               action_i,
  input  logic signed [31:0] grad_out_i,
  input  logic signed [31:0] activation_i,
  input  logic               last_element_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] input_gradient_o,
  output logic signed [31:0] scale_gradient_o,
  output logic signed [31:0] shift_gradient_o,
  output logic               kind_o,
  output logic               last_result_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  bnb_pkg::q_t   scale_q, mean_q;
  logic [30:0]   rstd_q;

  logic          grad_q, last_q;
  bnb_pkg::q_t   dout_q, xc_q, dxhat_q, xhat_q;
  bnb_pkg::acc_t t_q, u_q;

  bnb_pkg::acc_t sgs_q, shs_q, cps_q, sc_q;
  logic [CNT_W-1:0] cnt_q;
  logic [30:0]   factor_q;

  logic          out_valid_q;
  bnb_pkg::q_t   ig_q, sg_q, bg_q;
  logic          kind_q, lastr_q;

  bnb_pkg::acc_t mul_a, mul_b, mul_res, inner_a;
  logic          mul_done, div_done;
  logic [30:0]   quo;
  bnb_pkg::q_t   xc_in;

  assign xc_in = bnb_pkg::sat32(48'(activation_i) - 48'(mean_q));

  always_comb begin
    case (cmd_i.mul_op)
      bnb_pkg::OP_DXHAT: begin mul_a = 48'(dout_q);     mul_b = 48'(scale_q);  end
      bnb_pkg::OP_XHAT:  begin mul_a = 48'(xc_q);       mul_b = 48'(rstd_q);   end
      bnb_pkg::OP_R2:    begin mul_a = 48'(rstd_q);     mul_b = 48'(rstd_q);   end
      bnb_pkg::OP_T1:    begin mul_a = t_q;             mul_b = 48'(dxhat_q);  end
      bnb_pkg::OP_CT:    begin mul_a = t_q;             mul_b = 48'(xc_q);     end
      bnb_pkg::OP_DG:    begin mul_a = 48'(dout_q);     mul_b = 48'(xhat_q);   end
      // A plain integer product goes through the Q16.16 unit with the count
      // pre-shifted by the fraction width.
      bnb_pkg::OP_MT:    begin mul_a = 48'({cnt_q, 16'h0000}); mul_b = 48'(dxhat_q); end
      bnb_pkg::OP_CX:    begin mul_a = cps_q;           mul_b = 48'(xc_q);     end
      bnb_pkg::OP_DX:    begin mul_a = 48'(factor_q);   mul_b = t_q;           end
      default:           begin mul_a = '0;              mul_b = '0;            end
    endcase
  end

  bnb_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  bnb_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (rstd_q),
    .den_i   (cnt_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign inner_a = bnb_pkg::sat48(50'(t_q) - 50'(u_q));

  // Configuration and channel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= 32'sd65536;
      mean_q      <= '0;
      rstd_q      <= 31'd65536;
      sgs_q       <= '0;
      shs_q       <= '0;
      cps_q       <= '0;
      sc_q        <= '0;
      cnt_q       <= '0;
      factor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (bnb_pkg::cfg_reg_e'(cfg_index_i))
          bnb_pkg::REG_SCALE:   scale_q <= cfg_data_i;
          bnb_pkg::REG_MEAN:    mean_q  <= cfg_data_i;
          bnb_pkg::REG_INV_STD: rstd_q  <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (cmd_i.acc) begin
        sgs_q <= bnb_pkg::sat48(50'(sgs_q) + 50'(u_q));
        shs_q <= bnb_pkg::sat48(50'(shs_q) + 50'(dout_q));
        cps_q <= bnb_pkg::sat48(50'(cps_q) + 50'(t_q));
        sc_q  <= bnb_pkg::sat48(50'(sc_q) + 50'(dxhat_q));
        if (cnt_q < CNT_W'(MAX_ELEMENTS)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (div_done) begin
        factor_q <= quo;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (grad_q && last_q) begin
          sgs_q    <= '0;
          shs_q    <= '0;
          cps_q    <= '0;
          sc_q     <= '0;
          cnt_q    <= '0;
          factor_q <= '0;
        end
      end
    end
  end

  // Item registers, intermediate terms and the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      grad_q <= action_i;
      last_q <= last_element_i;
      dout_q <= grad_out_i;
      xc_q   <= xc_in;
    end
    if (mul_done) begin
      case (cmd_i.mul_op)
        bnb_pkg::OP_DXHAT: dxhat_q <= bnb_pkg::sat32(mul_res);
        bnb_pkg::OP_XHAT:  xhat_q  <= bnb_pkg::sat32(mul_res);
        bnb_pkg::OP_DG,
        bnb_pkg::OP_CX:    u_q     <= mul_res;
        default:           t_q     <= mul_res;
      endcase
    end
    if (cmd_i.inner) begin
      t_q <= bnb_pkg::sat48(50'(inner_a) - 50'(sc_q));
    end
    if (cmd_i.emit) begin
      kind_q <= grad_q;
      if (grad_q) begin
        ig_q    <= bnb_pkg::sat32(t_q);
        sg_q    <= '0;
        bg_q    <= '0;
        lastr_q <= last_q;
      end else begin
        ig_q    <= '0;
        sg_q    <= bnb_pkg::sat32(sgs_q);
        bg_q    <= bnb_pkg::sat32(shs_q);
        lastr_q <= 1'b1;
      end
    end
  end

  assign sts_o.mul_done  = mul_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign sts_o.grad_pass = grad_q;
  assign sts_o.last      = last_q;

  assign out_valid_o      = out_valid_q;
  assign input_gradient_o = ig_q;
  assign scale_gradient_o = sg_q;
  assign shift_gradient_o = bg_q;
  assign kind_o           = kind_q;
  assign last_result_o    = lastr_q;

endmodule

>>> src/bnb_ctrl.sv
// ----------------------------------------------------------------------------
// bnb_ctrl
// Sequencer: steps one item through the multiply, accumulate, divide and
// result stages of the datapath.
// ----------------------------------------------------------------------------
module bnb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bnb_pkg::sts_t sts_i,
  output bnb_pkg::cmd_t cmd_o
);

  bnb_pkg::ctrl_state_e state_q, state_d, mul_next;
  logic                 launched_q, launched_d;
  logic                 is_mul;
  bnb_pkg::mul_op_e     op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bnb_pkg::ST_IDLE;
      launched_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    launched_d       = launched_q;
    in_ready_o       = 1'b0;
    is_mul           = 1'b0;
    op               = bnb_pkg::OP_DXHAT;
    mul_next         = bnb_pkg::ST_IDLE;
    cmd_o.load       = 1'b0;
    cmd_o.mul_start  = 1'b0;
    cmd_o.acc        = 1'b0;
    cmd_o.inner      = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.emit       = 1'b0;

    case (state_q)
      bnb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bnb_pkg::ST_DXHAT;
        end
      end
      bnb_pkg::ST_DXHAT: begin
        is_mul   = 1'b1;
        op       = bnb_pkg::OP_DXHAT;
        mul_next = sts_i.grad_pass ? bnb_pkg::ST_MT : bnb_pkg::ST_XHAT;
      end
      bnb_pkg::ST_XHAT: begin
        is_mul = 1'b1; op = bnb_pkg::OP_XHAT; mul_next = bnb_pkg::ST_R2;
      end
      bnb_pkg::ST_R2: begin
        is_mul = 1'b1; op = bnb_pkg::OP_R2; mul_next = bnb_pkg::ST_T1;
      end
      bnb_pkg::ST_T1: begin
        is_mul = 1'b1; op = bnb_pkg::OP_T1; mul_next = bnb_pkg::ST_CT;
      end
      bnb_pkg::ST_CT: begin
        is_mul = 1'b1; op = bnb_pkg::OP_CT; mul_next = bnb_pkg::ST_DG;
      end
      bnb_pkg::ST_DG: begin
        is_mul = 1'b1; op = bnb_pkg::OP_DG; mul_next = bnb_pkg::ST_ACC;
      end
      bnb_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.last ? bnb_pkg::ST_DIV : bnb_pkg::ST_IDLE;
      end
      bnb_pkg::ST_DIV: begin
        cmd_o.div_start = !launched_q;
        if (!launched_q) begin
          launched_d = 1'b1;
        end
        if (sts_i.div_done) begin
          launched_d = 1'b0;
          state_d    = bnb_pkg::ST_EMIT;
        end
      end
      bnb_pkg::ST_MT: begin
        is_mul = 1'b1; op = bnb_pkg::OP_MT; mul_next = bnb_pkg::ST_CX;
      end
      bnb_pkg::ST_CX: begin
        is_mul = 1'b1; op = bnb_pkg::OP_CX; mul_next = bnb_pkg::ST_INNER;
      end
      bnb_pkg::ST_INNER: begin
        cmd_o.inner = 1'b1;
        state_d     = bnb_pkg::ST_DX;
      end
      bnb_pkg::ST_DX: begin
        is_mul = 1'b1; op = bnb_pkg::OP_DX; mul_next = bnb_pkg::ST_EMIT;
      end
      bnb_pkg::ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = bnb_pkg::ST_IDLE;
        end
      end
      default: state_d = bnb_pkg::ST_IDLE;
    endcase

    // Every multiply step issues one operation and waits for its result.
    if (is_mul) begin
      cmd_o.mul_start = !launched_q;
      if (!launched_q) begin
        launched_d = 1'b1;
      end
      if (sts_i.mul_done) begin
        launched_d = 1'b0;
        state_d    = mul_next;
      end
    end
    cmd_o.mul_op = op;
  end

  a_idle_not_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bnb_pkg::ST_IDLE) |-> !launched_q)
    else $error("operation outstanding while idle");

  a_mul_done_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> launched_q)
    else $error("multiplier result without an issued operation");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == bnb_pkg::ST_DIV) && launched_q)
    else $error("divider result outside the divide step");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == bnb_pkg::ST_DXHAT) && !launched_q)
    else $error("accepted item did not start its sequence");

endmodule
